/* design/tods_pkg.sv */
// Package for the time-of-day segment table: segment record, cell flags,
// command bundle, operation and status codes, default settings.
// No dependencies.
`default_nettype none

package tods_pkg;

  // Default table depth handed to the top level
  localparam int MAX_SEGMENTS_DEF = 16;

  // Count width covering the full depth range (counts up to 127)
  localparam int CNT_W = 7;

  // Field widths
  localparam int TIME_W = 17;
  localparam int VAL_W  = 16;

  // Default settings, hundredths
  localparam logic [VAL_W-1:0] DEF_CARB   = 16'd1000;
  localparam logic [VAL_W-1:0] DEF_CORR   = 16'd200;
  localparam logic [VAL_W-1:0] DEF_TARGET = 16'd550;
  localparam logic [VAL_W-1:0] DEF_BASAL  = 16'd100;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  // One schedule segment
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [VAL_W-1:0]  carb;
    logic [VAL_W-1:0]  corr;
    logic [VAL_W-1:0]  target;
    logic [VAL_W-1:0]  basal;
  } seg_t;

  // Per-cell compare results shared with the neighbours
  typedef struct packed {
    logic valid;   // cell lies inside the stored count
    logic le_new;  // start <= new segment start
    logic lt_new;  // start <  new segment start
    logic le_q;    // start <= query time
  } flg_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic              we;
    op_t               op;
    logic [3:0]        idx;
    logic [CNT_W-1:0]  count;
    seg_t              seg;
    logic [TIME_W-1:0] query;
  } cmd_t;

  localparam seg_t SEG_DEFAULT = '{start: '0, carb: DEF_CARB, corr: DEF_CORR,
                                   target: DEF_TARGET, basal: DEF_BASAL};

endpackage

`default_nettype wire

/* design/tods_cell.sv */
// One table cell: holds a segment, compares it against the command and
// picks its next content from itself, its neighbours or the new segment.
// Depends on tods_pkg.
`default_nettype none

module tods_cell import tods_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire seg_t left_seg,
  input  wire seg_t right_seg,
  input  wire flg_t left_flg,
  input  wire flg_t right_flg,
  input  wire logic leq0,
  output seg_t      seg,
  output flg_t      flg,
  output logic      sel
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  logic [CNT_W-1:0] idx_ext;
  assign idx_ext = CNT_W'(cmd.idx);

  // Local compares, handed to both neighbours
  assign flg.valid  = POS < cmd.count;
  assign flg.le_new = seg.start <= cmd.seg.start;
  assign flg.lt_new = seg.start < cmd.seg.start;
  assign flg.le_q   = seg.start <= cmd.query;

  // Lookup: last entry at or before the query, or wrap to the last entry
  assign sel = (flg.valid && flg.le_q && !(right_flg.valid && right_flg.le_q)) ||
               ((POS + 1'b1) == cmd.count && !leq0);

  // Next content. The table with the affected entry taken out (or left
  // alone on insert) is the remainder list; the new segment goes after every
  // remainder entry that sorts before it.
  seg_t seg_next;
  seg_t own_seg, lft_seg;
  flg_t own_flg, lft_flg;
  logic own_valid, lft_valid, own_bef, lft_bef, own_from_right, lft_from_own;

  always_comb begin
    own_from_right = (cmd.op == OP_REPLACE || cmd.op == OP_REMOVE) && POS >= idx_ext;
    lft_from_own   = (cmd.op == OP_REPLACE) && POS > idx_ext;
    own_seg = own_from_right ? right_seg : seg;
    own_flg = own_from_right ? right_flg : flg;
    lft_seg = lft_from_own ? seg : left_seg;
    lft_flg = lft_from_own ? flg : left_flg;

    if (cmd.op == OP_REPLACE) begin
      own_valid = (POS + 1'b1) < cmd.count;
      lft_valid = (IDX != 0) && POS < cmd.count;
      // stable order: equal starts keep their side of the replaced entry
      own_bef = own_flg.lt_new || (own_flg.le_new && POS < idx_ext);
      lft_bef = lft_flg.lt_new || (lft_flg.le_new && POS <= idx_ext);
    end else begin
      own_valid = POS < cmd.count;
      lft_valid = (IDX != 0) && POS <= cmd.count;
      // insert goes after equal starts
      own_bef = own_flg.le_new;
      lft_bef = lft_flg.le_new;
    end

    case (cmd.op)
      OP_INSERT, OP_REPLACE: begin
        if (own_valid && own_bef) begin
          seg_next = own_seg;
        end else if (lft_valid && !lft_bef) begin
          seg_next = lft_seg;
        end else begin
          seg_next = cmd.seg;
        end
      end
      OP_REMOVE: seg_next = own_seg;
      default:   seg_next = seg;
    endcase
  end

  // Storage: only the first cell has a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      if (IDX == 0) begin
        seg <= SEG_DEFAULT;
      end
    end else if (cmd.we) begin
      seg <= seg_next;
    end
  end

endmodule

`default_nettype wire

/* design/time_of_day_segment_table.sv */
// Time-of-day segment table top level: row of tods_cell, count, status and output register.
// A transaction's result sits in the output register in the cycle after acceptance.
// Throughput: one transaction per cycle; every cell compares and shifts in the same cycle.
// A result left waiting holds s_tready low until the cycle in which it is taken.
// Reset: entry 0 holds midnight defaults, count is 1, the output register is empty.
// Depends on tods_pkg and tods_cell.
`default_nettype none

module time_of_day_segment_table import tods_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // seg_index[3:0] seg_start[20:4] carb_ratio[36:21] correction_factor[52:37]
  // target_glucose[68:53] basal_rate[84:69] query_time[101:85], zero pad
  input  wire logic [103:0] s_tdata,
  // op[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0] found[2] hit_index[6:3] out_carb_ratio[22:7] out_correction[38:23]
  // out_target[54:39] out_basal[70:55] entry_count[75:71], zero pad
  output logic [79:0]       m_tdata
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  logic [CW-1:0] count, count_next;
  logic          s_acc;
  op_t           op_in;
  seg_t          seg_in;
  logic [1:0]    status;
  cmd_t          cmd;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign op_in    = op_t'(s_tuser);
  assign seg_in   = '{start: s_tdata[20:4], carb: s_tdata[36:21], corr: s_tdata[52:37],
                      target: s_tdata[68:53], basal: s_tdata[84:69]};

  // Status and new count
  always_comb begin
    status     = ST_OK;
    count_next = count;
    case (op_in)
      OP_INSERT: begin
        if (count >= CNT_MAX) begin
          status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_REPLACE: begin
        if (CNT_W'(s_tdata[3:0]) >= CNT_W'(count)) begin
          status = ST_BAD_INDEX;
        end
      end
      OP_REMOVE: begin
        if (CNT_W'(s_tdata[3:0]) >= CNT_W'(count)) begin
          status = ST_BAD_INDEX;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Broadcast command
  assign cmd = '{we: s_acc && status == ST_OK && op_in != OP_LOOKUP, op: op_in,
                 idx: s_tdata[3:0], count: CNT_W'(count), seg: seg_in,
                 query: s_tdata[101:85]};

  // Cell row
  seg_t                    seg_arr  [MAX_SEGMENTS];
  flg_t                    flg_arr  [MAX_SEGMENTS];
  seg_t                    lseg_arr [MAX_SEGMENTS];
  seg_t                    rseg_arr [MAX_SEGMENTS];
  flg_t                    lflg_arr [MAX_SEGMENTS];
  flg_t                    rflg_arr [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] sel_vec;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    if (g == 0) begin : g_lend
      assign lseg_arr[g] = '0;
      assign lflg_arr[g] = '0;
    end else begin : g_lnb
      assign lseg_arr[g] = seg_arr[g-1];
      assign lflg_arr[g] = flg_arr[g-1];
    end
    if (g == MAX_SEGMENTS - 1) begin : g_rend
      assign rseg_arr[g] = '0;
      assign rflg_arr[g] = '0;
    end else begin : g_rnb
      assign rseg_arr[g] = seg_arr[g+1];
      assign rflg_arr[g] = flg_arr[g+1];
    end

    tods_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_seg  (lseg_arr[g]),
      .right_seg (rseg_arr[g]),
      .left_flg  (lflg_arr[g]),
      .right_flg (rflg_arr[g]),
      .leq0      (flg_arr[0].le_q),
      .seg       (seg_arr[g]),
      .flg       (flg_arr[g]),
      .sel       (sel_vec[g])
    );
  end

  // Gather the selected entry (selection is one-hot)
  seg_t          hit_seg;
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit_seg = '0;
    hit_idx = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (sel_vec[i]) begin
        hit_seg = hit_seg | seg_arr[i];
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Result fields
  logic          found;
  logic [IW+3:0] hit_wide;
  logic [CW+4:0] cnt_wide;
  seg_t          res_seg;
  always_comb begin
    found    = 1'b0;
    hit_wide = '0;
    res_seg  = '0;
    if (op_in == OP_LOOKUP) begin
      if (count == '0) begin
        res_seg = SEG_DEFAULT;
      end else begin
        found    = 1'b1;
        hit_wide = (IW+4)'(hit_idx);
        res_seg  = hit_seg;
      end
    end
    cnt_wide = (CW+5)'(count_next);
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else if (s_acc) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      m_tdata <= {4'b0, cnt_wide[4:0], res_seg.basal, res_seg.target, res_seg.corr,
                  res_seg.carb, hit_wide[3:0], found, status};
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above table depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    s_acc && op_in == OP_INSERT && count == CNT_MAX |=> count == $past(count))
    else $error("insert into full table changed the count");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    s_acc && op_in == OP_LOOKUP && count != '0 |-> $onehot(sel_vec))
    else $error("lookup did not select exactly one entry");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> m_tvalid)
    else $error("accepted transaction gave no result");

endmodule

`default_nettype wire

/* tb/sv/time_of_day_segment_table_tb.sv */
// Self-checking bench for time_of_day_segment_table: drives schedule commands on the slave
// stream, predicts each result from its own copy of the table and checks the master stream.
// Depends on tods_pkg and the time_of_day_segment_table RTL.
module time_of_day_segment_table_tb import tods_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = 16;
  localparam int IDLE_PCT    = 26;
  localparam int RX_HOLD     = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_BATCHES   = 10;
  localparam int BATCH_LEN   = 50;

  // One command as it travels on the slave side
  typedef struct packed {
    op_t               op;
    logic [3:0]        idx;
    seg_t              seg;
    logic [TIME_W-1:0] query;
  } sched_cmd_t;

  // One result as it travels on the master side, highest field first
  typedef struct packed {
    logic [4:0]       count;
    logic [VAL_W-1:0] basal;
    logic [VAL_W-1:0] target;
    logic [VAL_W-1:0] corr;
    logic [VAL_W-1:0] carb;
    logic [3:0]       hit;
    logic             found;
    logic [1:0]       status;
  } sched_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;

  // Bench state
  sched_cmd_t    cmd_backlog[$];
  sched_result_t result_due[$];
  sched_cmd_t    cmd_on_bus;
  sched_result_t got_res, want_res;
  seg_t          sched[TBL_DEPTH];
  int            sched_len;
  int            gen_len;
  int            mismatches = 0;
  int            results_seen = 0;
  int            cycle_cnt = 0;
  int            n_op[4] = '{0, 0, 0, 0};
  int            n_empty_lookup = 0;
  int            n_flag_full = 0;
  int            n_flag_index = 0;
  bit            calm = 1'b0;
  int            hold_req = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  time_of_day_segment_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Schedule model: applies one command to the shadow table and returns its result
  function automatic sched_result_t apply_schedule_cmd(sched_cmd_t c);
    sched_result_t r;
    seg_t          tmp;
    int            pos;
    int            j;
    r = '0;
    n_op[c.op]++;
    case (c.op)
      OP_LOOKUP: begin
        if (sched_len == 0) begin
          r.carb   = DEF_CARB;
          r.corr   = DEF_CORR;
          r.target = DEF_TARGET;
          r.basal  = DEF_BASAL;
          n_empty_lookup++;
        end else begin
          // latest start at or before the query; nothing there wraps to the last entry
          pos = sched_len - 1;
          for (int i = 0; i < sched_len; i++)
            if (sched[i].start <= c.query) pos = i;
          r.found  = 1'b1;
          r.hit    = pos[3:0];
          r.carb   = sched[pos].carb;
          r.corr   = sched[pos].corr;
          r.target = sched[pos].target;
          r.basal  = sched[pos].basal;
        end
      end
      OP_INSERT: begin
        if (sched_len >= TBL_DEPTH) begin
          r.status = ST_FULL;
          n_flag_full++;
        end else begin
          // first entry starting strictly later; equal starts stay ahead of the new one
          pos = sched_len;
          for (int i = sched_len - 1; i >= 0; i--)
            if (sched[i].start > c.seg.start) pos = i;
          for (int i = sched_len; i > pos; i--)
            sched[i] = sched[i-1];
          sched[pos] = c.seg;
          sched_len++;
        end
      end
      OP_REPLACE: begin
        if (c.idx >= sched_len) begin
          r.status = ST_BAD_INDEX;
          n_flag_index++;
        end else begin
          sched[c.idx] = c.seg;
          // stable insertion sort on start
          for (int i = 1; i < sched_len; i++) begin
            tmp = sched[i];
            j = i;
            while (j > 0 && sched[j-1].start > tmp.start) begin
              sched[j] = sched[j-1];
              j--;
            end
            sched[j] = tmp;
          end
        end
      end
      default: begin
        if (c.idx >= sched_len) begin
          r.status = ST_BAD_INDEX;
          n_flag_index++;
        end else begin
          for (int i = c.idx; i + 1 < sched_len; i++)
            sched[i] = sched[i+1];
          sched_len--;
        end
      end
    endcase
    r.count = sched_len[4:0];
    return r;
  endfunction

  function automatic void cmp_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  // Sender: one transaction per handshake, random gaps unless calm
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        result_due.push_back(apply_schedule_cmd(cmd_on_bus));
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cmd_on_bus = cmd_backlog.pop_front();
          s_tdata  <= {2'b00, cmd_on_bus.query, cmd_on_bus.seg.basal, cmd_on_bus.seg.target,
                       cmd_on_bus.seg.corr, cmd_on_bus.seg.carb, cmd_on_bus.seg.start,
                       cmd_on_bus.idx};
          s_tuser  <= cmd_on_bus.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got_res = m_tdata[75:0];
      if (result_due.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatches++;
      end else begin
        want_res = result_due.pop_front();
        cmp_field("status", want_res.status, got_res.status);
        cmp_field("found", want_res.found, got_res.found);
        cmp_field("hit_index", want_res.hit, got_res.hit);
        cmp_field("out_carb_ratio", want_res.carb, got_res.carb);
        cmp_field("out_correction", want_res.corr, got_res.corr);
        cmp_field("out_target", want_res.target, got_res.target);
        cmp_field("out_basal", want_res.basal, got_res.basal);
        cmp_field("entry_count", want_res.count, got_res.count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("time_of_day_segment_table regression: fail");
      $finish;
    end
  end

  task automatic push_cmd(op_t op, int idx, int start, int carb, int corr, int target,
                          int basal, int query);
    sched_cmd_t c;
    c.op         = op;
    c.idx        = idx[3:0];
    c.seg.start  = start[TIME_W-1:0];
    c.seg.carb   = carb[VAL_W-1:0];
    c.seg.corr   = corr[VAL_W-1:0];
    c.seg.target = target[VAL_W-1:0];
    c.seg.basal  = basal[VAL_W-1:0];
    c.query      = query[TIME_W-1:0];
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_drained();
    while (!(cmd_backlog.size() == 0 && !s_tvalid && result_due.size() == 0))
      @(posedge clk);
  endtask

  // Times lean on hour marks so equal starts and exact hits come up often
  function automatic int rand_time();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      return $urandom_range(0, 23) * 3600;
    else if (sel < 40) return ($urandom_range(0, 1) == 0) ? 0 : 86399;
    else if (sel < 46) return $urandom_range(0, 131071);
    else               return $urandom_range(0, 86399);
  endfunction

  function automatic int rand_setting();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)      return 0;
    else if (sel == 1) return 65535;
    else               return $urandom_range(0, 65535);
  endfunction

  // Random command, weighted by the table fill so it keeps cycling empty to full
  task automatic push_random_cmd();
    int   sel;
    int   idx;
    int   ins_w;
    int   rem_w;
    op_t  op;
    ins_w = (gen_len < 4) ? 40 : ((gen_len >= TBL_DEPTH) ? 10 : 22);
    rem_w = (gen_len > 12) ? 30 : 15;
    sel = $urandom_range(0, 99);
    if (sel < ins_w)                   op = OP_INSERT;
    else if (sel < ins_w + rem_w)      op = OP_REMOVE;
    else if (sel < ins_w + rem_w + 15) op = OP_REPLACE;
    else                               op = OP_LOOKUP;
    if (gen_len > 0 && $urandom_range(0, 9) != 0) idx = $urandom_range(0, gen_len - 1);
    else                                          idx = $urandom_range(0, 15);
    if (op == OP_INSERT && gen_len < TBL_DEPTH) gen_len++;
    if (op == OP_REMOVE && idx < gen_len) gen_len--;
    push_cmd(op, idx, rand_time(), rand_setting(), rand_setting(), rand_setting(),
             rand_setting(), rand_time());
  endtask

  initial begin
    sched_len = 1;
    sched[0] = SEG_DEFAULT;
    for (int i = 1; i < TBL_DEPTH; i++) sched[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: single entry, empty table, bad indexes, equal starts, wrap, full table
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 86399);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 131071);
    push_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(OP_REPLACE, 0, 100, 1, 2, 3, 4, 0);
    push_cmd(OP_INSERT, 15, 43200, 65535, 65535, 65535, 65535, 0);
    push_cmd(OP_INSERT, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(OP_INSERT, 0, 43200, 11, 22, 33, 44, 0);
    push_cmd(OP_INSERT, 0, 131071, 5, 6, 7, 8, 0);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 43200);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 86399);
    push_cmd(OP_REPLACE, 2, 43200, 99, 98, 97, 96, 0);
    push_cmd(OP_REPLACE, 3, 10, 12, 13, 14, 15, 0);
    push_cmd(OP_REPLACE, 15, 10, 0, 0, 0, 0, 0);
    push_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 5);
    for (int i = 0; i < 14; i++)
      push_cmd(OP_INSERT, 0, (i % 4) * 20000, 1000 + i, 200 + i, 550 + i, 100 + i, 0);
    push_cmd(OP_INSERT, 0, 500, 1, 1, 1, 1, 0);
    push_cmd(OP_REPLACE, 15, 0, 65535, 0, 65535, 0, 0);
    push_cmd(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 131071);
    wait_drained();

    // Random: first batch meets a long receiver hold, one batch runs without gaps,
    // and the sender drains fully once midway
    gen_len = sched_len;
    for (int b = 0; b < N_BATCHES; b++) begin
      if (b == 6) wait_drained();
      calm = (b == 4);
      if (b == 0) hold_req++;
      for (int i = 0; i < BATCH_LEN; i++) push_random_cmd();
      while (cmd_backlog.size() > 10) @(posedge clk);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d lookups (%0d on an empty table), %0d inserts, %0d replaces, %0d removes",
             n_op[OP_LOOKUP], n_empty_lookup, n_op[OP_INSERT], n_op[OP_REPLACE],
             n_op[OP_REMOVE]);
    $display("%0d inserts refused as full, %0d bad indexes, %0d results checked",
             n_flag_full, n_flag_index, results_seen);
    if (mismatches == 0 && result_due.size() == 0) begin
      $display("time_of_day_segment_table regression: pass");
    end else begin
      $display("time_of_day_segment_table regression: fail");
    end
    $finish;
  end

endmodule
